// ===== hdl/sparse_column_window_neighbours_assert.svh =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_WINDOW_NEIGHBOURS_ASSERT_SVH
`define SPARSE_COLUMN_WINDOW_NEIGHBOURS_ASSERT_SVH

// Invariant that holds on every clock edge out of reset
`define SCW_CHECK(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define SCW_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SCW_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/scw_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: package
// Shared constants, state codes, evaluation record and count helper.
// ----------------------------------------------------------------------------
package scw_pkg;

    localparam int unsigned WINDOW_DEPTH = 64;
    localparam int unsigned ROW_BITS     = 31;
    localparam int unsigned MAX_RESULTS  = 64;
    localparam int unsigned COUNT_W      = 7;
    localparam int unsigned DIST_W       = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd126;
    localparam logic [DIST_W-1:0]  DIST_RESET = 6'd1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FINAL = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    // Result of comparing one pending entry against the incoming row
    typedef struct packed {
        logic               hit;
        logic               reach_past;
        logic [COUNT_W-1:0] count;
    } t_eval;

    // Saturating increment of a neighbour count
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
    endfunction

endpackage

// ===== hdl/scw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: configuration channel
// Write channel carrying the window distance register.
// ----------------------------------------------------------------------------
interface scw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [scw_pkg::DIST_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/scw_in_if.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: input channel
// One nonzero per transaction: row index and end-of-column flag.
// ----------------------------------------------------------------------------
interface scw_in_if #(
    parameter int unsigned ROW_BITS = scw_pkg::ROW_BITS
);
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_index;
    logic                column_end;

    modport source (output valid, row_index, column_end, input ready);
    modport sink   (input valid, row_index, column_end, output ready);
endinterface

// ===== hdl/scw_out_if.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: result channel
// One finished nonzero per transaction with its neighbour count.
// ----------------------------------------------------------------------------
interface scw_out_if #(
    parameter int unsigned ROW_BITS = scw_pkg::ROW_BITS
);
    logic                         valid;
    logic                         ready;
    logic [ROW_BITS-1:0]          entry_row;
    logic [scw_pkg::COUNT_W-1:0]  neighbour_count;
    logic                         run_last;

    modport source (output valid, entry_row, neighbour_count, run_last, input ready);
    modport sink   (input valid, entry_row, neighbour_count, run_last, output ready);
endinterface

// ===== hdl/sparse_column_window_neighbours.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: top level
// Counts same-column neighbours of each nonzero within a row window and
// retires finished entries oldest first.
// ----------------------------------------------------------------------------
// Pending nonzeros live in a circular buffer held in one single-port-read RAM
// (row and count per word, at most min(WINDOW_DEPTH, 64) - 1 entries). Each
// input transaction walks every pending entry once through the RAM read port,
// bumps counts, retires the leading entries that the new row has passed (the
// oldest also when the buffer is full, all at column end) and appends the
// new row. An item goes through accept, a walk of each pending entry, placing
// the new entry and closing the run; result stalls can hold the walk, the
// placing and the close. The last result of an item carries run_last. No
// item is taken while one is in progress. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sparse_column_window_neighbours_assert.svh"

module sparse_column_window_neighbours #(
    parameter int unsigned WINDOW_DEPTH = scw_pkg::WINDOW_DEPTH,
    parameter int unsigned ROW_BITS     = scw_pkg::ROW_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scw_cfg_if.sink          i_cfg,
    scw_in_if.sink           i_item,
    scw_out_if.source        o_result
);

    localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
    localparam int unsigned CAP   = ((WINDOW_DEPTH < scw_pkg::MAX_RESULTS) ?
                                     WINDOW_DEPTH : scw_pkg::MAX_RESULTS) - 1;
    localparam int unsigned FW    = $clog2(CAP + 1);
    localparam int unsigned CW    = scw_pkg::COUNT_W;
    localparam int unsigned MEM_W = ROW_BITS + CW;

    // Circular pointer advance
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    scw_pkg::t_state r_state, n_state;

    logic [scw_pkg::DIST_W-1:0] r_distance;
    logic [ROW_BITS-1:0]        r_row, n_row;
    logic                       r_end, n_end;
    logic [CW-1:0]              r_own, n_own;
    logic                       r_prefix, n_prefix;
    logic                       r_first, n_first;
    logic [AW-1:0]              r_head, n_head;
    logic [FW-1:0]              r_fill, n_fill;
    logic [AW-1:0]              r_rd_addr, n_rd_addr;
    logic [AW-1:0]              r_wb_addr, n_wb_addr;
    logic [FW-1:0]              r_proc_left, n_proc_left;

    logic                       r_cand_valid, n_cand_valid;
    logic [ROW_BITS-1:0]        r_cand_row, n_cand_row;
    logic [CW-1:0]              r_cand_count, n_cand_count;

    logic                       r_out_valid, n_out_valid;
    logic [ROW_BITS-1:0]        r_out_row, n_out_row;
    logic [CW-1:0]              r_out_count, n_out_count;
    logic                       r_out_last, n_out_last;

    logic                       accept;
    logic                       out_free;
    logic                       forced;
    logic                       scan_emit;
    logic                       new_emit;
    logic                       want_emit;
    logic                       blocked;
    logic                       scan_go;
    logic                       final_go;
    logic                       flush_go;
    logic                       push_cand;

    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [MEM_W-1:0]           ram_wr_data;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [MEM_W-1:0]           ram_rd_data;
    logic [ROW_BITS-1:0]        q_row;
    logic [CW-1:0]              q_count;
    scw_pkg::t_eval             ev;

    // Pending entry store
    scw_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign q_row   = ram_rd_data[ROW_BITS-1:0];
    assign q_count = ram_rd_data[MEM_W-1:ROW_BITS];

    // Compare the entry under the read port with the current row
    scw_entry_eval #(
        .ROW_BITS (ROW_BITS)
    ) u_eval (
        .i_row         (r_row),
        .i_entry_row   (q_row),
        .i_entry_count (q_count),
        .i_distance    (r_distance),
        .o_eval        (ev)
    );

    // Handshakes
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == scw_pkg::S_IDLE);
    assign accept       = i_item.valid && i_item.ready;

    assign o_result.valid           = r_out_valid;
    assign o_result.entry_row       = r_out_row;
    assign o_result.neighbour_count = r_out_count;
    assign o_result.run_last        = r_out_last;

    assign out_free = !r_out_valid || o_result.ready;

    // Retire decisions: the oldest entry leaves early when the buffer is full
    assign forced    = r_first && (r_fill == FW'(CAP));
    assign scan_emit = r_end || (r_prefix && ev.reach_past) || forced;
    assign new_emit  = r_end || (r_prefix && (r_distance == '0));
    assign want_emit = ((r_state == scw_pkg::S_SCAN) && scan_emit) ||
                       ((r_state == scw_pkg::S_FINAL) && new_emit);
    assign blocked   = want_emit && r_cand_valid && !out_free;

    assign scan_go  = (r_state == scw_pkg::S_SCAN) && !blocked;
    assign final_go = (r_state == scw_pkg::S_FINAL) && !blocked;
    assign flush_go = (r_state == scw_pkg::S_FLUSH) && (!r_cand_valid || out_free);

    assign push_cand = r_cand_valid &&
                       ((scan_go && scan_emit) || (final_go && new_emit) || flush_go);

    // RAM access: read ahead during the walk, write back kept entries
    assign ram_rd_en   = (accept && (r_fill != '0)) ||
                         (scan_go && (r_proc_left > FW'(1)));
    assign ram_rd_addr = accept ? r_head : r_rd_addr;
    assign ram_wr_en   = (scan_go && !scan_emit) || (final_go && !new_emit);
    assign ram_wr_addr = r_wb_addr;
    assign ram_wr_data = (r_state == scw_pkg::S_SCAN) ? {ev.count, q_row} : {r_own, r_row};

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_end        = r_end;
        n_own        = r_own;
        n_prefix     = r_prefix;
        n_first      = r_first;
        n_head       = r_head;
        n_fill       = r_fill;
        n_rd_addr    = r_rd_addr;
        n_wb_addr    = r_wb_addr;
        n_proc_left  = r_proc_left;
        n_cand_valid = r_cand_valid;
        n_cand_row   = r_cand_row;
        n_cand_count = r_cand_count;
        n_out_valid  = r_out_valid;
        n_out_row    = r_out_row;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;

        // Advance the output register
        if (push_cand) begin
            n_out_valid = 1'b1;
            n_out_row   = r_cand_row;
            n_out_count = r_cand_count;
            n_out_last  = (r_state == scw_pkg::S_FLUSH);
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            scw_pkg::S_IDLE: begin
                if (accept) begin
                    n_row       = i_item.row_index;
                    n_end       = i_item.column_end;
                    n_own       = '0;
                    n_prefix    = 1'b1;
                    n_first     = 1'b1;
                    n_wb_addr   = r_head;
                    n_rd_addr   = ptr_inc(r_head);
                    n_proc_left = r_fill;
                    n_state     = (r_fill == '0) ? scw_pkg::S_FINAL : scw_pkg::S_SCAN;
                end
            end
            scw_pkg::S_SCAN: begin
                if (scan_go) begin
                    n_own       = ev.hit ? scw_pkg::sat_inc(r_own) : r_own;
                    n_prefix    = r_prefix && ev.reach_past;
                    n_first     = 1'b0;
                    n_wb_addr   = ptr_inc(r_wb_addr);
                    n_proc_left = r_proc_left - 1'b1;
                    if (r_proc_left > FW'(1)) begin
                        n_rd_addr = ptr_inc(r_rd_addr);
                    end else begin
                        n_state = scw_pkg::S_FINAL;
                    end
                    // Retire this entry into the candidate slot
                    if (scan_emit) begin
                        n_head       = ptr_inc(r_head);
                        n_fill       = r_fill - 1'b1;
                        n_cand_valid = 1'b1;
                        n_cand_row   = q_row;
                        n_cand_count = ev.count;
                    end
                end
            end
            scw_pkg::S_FINAL: begin
                if (final_go) begin
                    if (new_emit) begin
                        n_cand_valid = 1'b1;
                        n_cand_row   = r_row;
                        n_cand_count = r_own;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = scw_pkg::S_FLUSH;
                end
            end
            scw_pkg::S_FLUSH: begin
                if (flush_go) begin
                    n_cand_valid = 1'b0;
                    n_state      = scw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scw_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scw_pkg::S_IDLE;
            r_distance   <= scw_pkg::DIST_RESET;
            r_head       <= '0;
            r_fill       <= '0;
            r_cand_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_fill       <= n_fill;
            r_cand_valid <= n_cand_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_distance <= i_cfg.data;
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_end        <= n_end;
        r_own        <= n_own;
        r_prefix     <= n_prefix;
        r_first      <= n_first;
        r_rd_addr    <= n_rd_addr;
        r_wb_addr    <= n_wb_addr;
        r_proc_left  <= n_proc_left;
        r_cand_row   <= n_cand_row;
        r_cand_count <= n_cand_count;
        r_out_row    <= n_out_row;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    // Checks
    `SCW_CHECK(a_fill_cap, i_clk, i_rst_n, r_fill <= FW'(CAP), "pending fill above capacity")
    `SCW_IMPLY(a_idle_no_cand, i_clk, i_rst_n, r_state == scw_pkg::S_IDLE, !r_cand_valid, "candidate left over in idle")
    `SCW_IMPLY(a_no_rw_clash, i_clk, i_rst_n, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "read and write hit the same entry")
    `SCW_NEXT(a_flush_closes, i_clk, i_rst_n, flush_go && r_cand_valid, o_result.valid && o_result.run_last, "closing result not marked last")

endmodule

// ===== hdl/scw_ram.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module scw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: hold data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/scw_entry_eval.sv =====
// ----------------------------------------------------------------------------
// Sparse column window neighbours: entry evaluation
// Compares one pending entry with the incoming row: window hit, whether the
// new row lies far enough past it to retire it, and its updated count.
// ----------------------------------------------------------------------------
module scw_entry_eval #(
    parameter int unsigned ROW_BITS = scw_pkg::ROW_BITS
) (
    input  logic [ROW_BITS-1:0]          i_row,
    input  logic [ROW_BITS-1:0]          i_entry_row,
    input  logic [scw_pkg::COUNT_W-1:0]  i_entry_count,
    input  logic [scw_pkg::DIST_W-1:0]   i_distance,
    output scw_pkg::t_eval               o_eval
);

    logic [ROW_BITS:0]   diff_up;
    logic [ROW_BITS:0]   diff_dn;
    logic                row_ge;
    logic [ROW_BITS-1:0] dist_abs;
    logic [ROW_BITS-1:0] dist_wide;

    // Distance in both directions
    assign diff_up   = {1'b0, i_row} - {1'b0, i_entry_row};
    assign diff_dn   = {1'b0, i_entry_row} - {1'b0, i_row};
    assign row_ge    = ~diff_up[ROW_BITS];
    assign dist_abs  = row_ge ? diff_up[ROW_BITS-1:0] : diff_dn[ROW_BITS-1:0];
    assign dist_wide = {{(ROW_BITS - scw_pkg::DIST_W){1'b0}}, i_distance};

    // Hit, retire test and updated count
    always_comb begin
        o_eval.hit        = (dist_abs <= dist_wide);
        o_eval.reach_past = row_ge && (diff_up[ROW_BITS-1:0] >= dist_wide);
        o_eval.count      = o_eval.hit ? scw_pkg::sat_inc(i_entry_count) : i_entry_count;
    end

endmodule

// ===== dv/sparse_column_window_neighbours_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse column window neighbours: scoreboard
// Follows the window distance register and the pending nonzeros of the open
// column, predicts every finished entry and compares each result transaction
// with the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_column_window_neighbours_checker
    import scw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    scw_cfg_if   i_cfg,
    scw_in_if    i_item,
    scw_out_if   i_result,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_entries_checked
);

    localparam int KEEP_MAX =
        ((WINDOW_DEPTH < MAX_RESULTS) ? WINDOW_DEPTH : MAX_RESULTS) - 1;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COUNT_W-1:0]  count;
    } pending_nz_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } finished_nz_t;

    logic [DIST_W-1:0] window_dist;
    pending_nz_t       column_window[$];
    finished_nz_t      finished_q[$];
    finished_nz_t      want;

    // Saturating neighbour count
    function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

    // Add one nonzero to the window and queue the entries it retires
    task automatic retire_nonzero(input logic [ROW_BITS-1:0] new_row, input logic col_end);
        logic [ROW_BITS-1:0] row_gap;
        logic [COUNT_W-1:0]  own;
        int                  n_out;
        pending_nz_t         head;
        own = '0;
        foreach (column_window[i]) begin
            row_gap = (new_row >= column_window[i].row) ? new_row - column_window[i].row
                                                        : column_window[i].row - new_row;
            if (row_gap <= window_dist) begin
                column_window[i].count = bump_count(column_window[i].count);
                own = bump_count(own);
            end
        end
        column_window.push_back('{row: new_row, count: own});

        // Column end flushes everything; otherwise drop entries no later row can reach
        n_out = 0;
        if (col_end) begin
            n_out = column_window.size();
        end else begin
            while (n_out < column_window.size() && new_row >= column_window[n_out].row &&
                   new_row - column_window[n_out].row >= window_dist)
                n_out++;
            // Force out the oldest when the buffer would overflow
            if (column_window.size() - n_out > KEEP_MAX)
                n_out = column_window.size() - KEEP_MAX;
        end
        for (int j = 0; j < n_out; j++) begin
            head = column_window.pop_front();
            finished_q.push_back('{row: head.row, count: head.count, last: (j == n_out - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_dist = DIST_RESET;
            column_window.delete();
            finished_q.delete();
            o_fail_count = 0;
            o_entries_checked = 0;
        end else begin
            // Track the register write transaction
            if (i_cfg.valid && i_cfg.ready)
                window_dist = i_cfg.data;

            // Compare a result transaction with the oldest prediction
            if (i_result.valid && i_result.ready) begin
                if (finished_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result row %0h count %0d last %0b",
                                 $time, i_result.entry_row, i_result.neighbour_count,
                                 i_result.run_last);
                end else begin
                    want = finished_q.pop_front();
                    o_entries_checked++;
                    if (i_result.entry_row !== want.row ||
                        i_result.neighbour_count !== want.count ||
                        i_result.run_last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS)
                            $display({"%0t: result mismatch, expected row %0h count %0d ",
                                      "last %0b, got row %0h count %0d last %0b"},
                                     $time, want.row, want.count, want.last,
                                     i_result.entry_row, i_result.neighbour_count,
                                     i_result.run_last);
                    end
                end
            end

            // Predict what the accepted nonzero retires
            if (i_item.valid && i_item.ready)
                retire_nonzero(i_item.row_index, i_item.column_end);
        end
        o_outstanding = finished_q.size();
    end

endmodule

// ===== dv/sparse_column_window_neighbours_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse column window neighbours: testbench top
// Drives directed and random columns of nonzeros under several window
// distances, stalls both channels at random, holds the result side off once
// for a long stretch, and reports the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module sparse_column_window_neighbours_tb;
    import scw_pkg::*;

    localparam logic [ROW_BITS-1:0] ROW_MAX = '1;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = WINDOW_DEPTH + 8;
    localparam int FLAT_LEN     = 130;
    localparam int BLOCKED_LEN  = 70;

    logic              i_clk;
    logic              i_rst_n;
    logic [DIST_W-1:0] cur_dist;
    int                fail_count;
    int                outstanding;
    int                entries_checked;
    int                sent_count;
    int                column_count;
    int                setting_count;

    scw_cfg_if cfg_ch();
    scw_in_if  item_ch();
    scw_out_if result_ch();

    sparse_column_window_neighbours dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    sparse_column_window_neighbours_checker nz_scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg_ch),
        .i_item            (item_ch),
        .i_result          (result_ch),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_entries_checked (entries_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle cycles before a transaction; every third stretch of 48 runs back to back
    function automatic int pick_gap(input int n);
        if ((n / 48) % 3 == 1)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Random starting row that leaves room for span more rows
    function automatic logic [31:0] pick_base(input logic [31:0] span);
        logic [31:0] top_base;
        logic [31:0] r;
        top_base = {1'b0, ROW_MAX} - span;
        case ($urandom_range(0, 7))
            0:       r = '0;
            1:       r = top_base;
            default: r = $urandom() >> 1;
        endcase
        return (r > top_base) ? top_base : r;
    endfunction

    // Offer one nonzero and hold it until accepted; returns at a falling edge
    task automatic send_nonzero(input logic [31:0] row, input logic col_end);
        int gap;
        gap = pick_gap(sent_count);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.row_index  <= row[ROW_BITS-1:0];
        item_ch.column_end <= col_end;
        do @(posedge i_clk); while (!item_ch.ready);
        sent_count++;
        if (col_end)
            column_count++;
        @(negedge i_clk);
    endtask

    // Drop valid, drain all expected results, then let the last item finish
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write the window distance while the block is idle
    task automatic set_distance(input logic [DIST_W-1:0] d);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_dist = d;
        setting_count++;
    endtask

    // Mostly rising columns with random content, some jittered rows and open ends
    task automatic random_phase(input int n_items);
        int          stop;
        int          len;
        int          max_step;
        int          jitter;
        logic [31:0] row;
        logic [31:0] base;
        bit          broken;
        bit          close;
        stop = sent_count + n_items;
        jitter = 2 * cur_dist + 4;
        while (sent_count < stop) begin
            broken = ($urandom_range(0, 9) < 2);
            close  = ($urandom_range(0, 9) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
            if (broken)
                len = $urandom_range(1, 16);
            // Trim the last column so the phase sends exactly its share
            if (len > stop - sent_count)
                len = stop - sent_count;
            case ($urandom_range(0, 4))
                0:       max_step = 5000;
                1:       max_step = cur_dist / 4 + 2;
                default: max_step = cur_dist + 2;
            endcase
            base = pick_base(len * max_step + jitter);
            row = base;
            for (int j = 0; j < len; j++) begin
                if (broken)
                    row = base + $urandom_range(0, jitter);
                send_nonzero(row, close && j == len - 1);
                row += $urandom_range(1, max_step);
            end
        end
    endtask

    // Result side: random stalls, one long hold-off so the block backs up
    initial begin : result_sink
        int taken;
        int hold;
        result_ch.ready = 1'b0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = (taken == HOLD_AFTER) ? LONG_HOLD : pick_gap(taken);
            if (hold > 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [31:0] base;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        item_ch.valid      = 1'b0;
        item_ch.row_index  = '0;
        item_ch.column_end = 1'b0;
        i_rst_n            = 1'b0;
        cur_dist           = DIST_RESET;
        sent_count         = 0;
        column_count       = 0;
        setting_count      = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Distance at its reset value: a chain of neighbours, top rows, bit patterns
        send_nonzero(0, 1'b0);
        send_nonzero(1, 1'b0);
        send_nonzero(2, 1'b1);
        send_nonzero(ROW_MAX, 1'b1);
        send_nonzero(ROW_MAX - 1, 1'b0);
        send_nonzero(ROW_MAX, 1'b1);
        send_nonzero(32'h2AAA_AAAA, 1'b0);
        send_nonzero(32'h5555_5555, 1'b1);
        // Equal and falling rows: equal counts, a high front holds the rest back
        send_nonzero(10, 1'b0);
        send_nonzero(10, 1'b0);
        send_nonzero(4, 1'b0);
        send_nonzero(11, 1'b0);
        send_nonzero(30, 1'b1);

        // Widest window: rows exactly at the distance and far apart
        set_distance(63);
        send_nonzero(100, 1'b0);
        send_nonzero(163, 1'b0);
        send_nonzero(164, 1'b0);
        send_nonzero(227, 1'b1);
        send_nonzero(0, 1'b0);
        send_nonzero(ROW_MAX, 1'b1);

        // Zero window: only equal rows count, each entry leaves at once
        set_distance(0);
        send_nonzero(5, 1'b0);
        send_nonzero(5, 1'b0);
        send_nonzero(6, 1'b1);

        set_distance(1);
        random_phase(40);

        set_distance(63);
        random_phase(10);
        // Equal rows keep every entry in reach: buffer overflow and count saturation
        base = pick_base(0);
        for (int j = 0; j < FLAT_LEN; j++)
            send_nonzero(base, j == FLAT_LEN - 1);
        // A high row at the front blocks the rising rows behind it
        base = pick_base(BLOCKED_LEN + 1000);
        send_nonzero(base + 1000, 1'b0);
        for (int j = 0; j < BLOCKED_LEN; j++)
            send_nonzero(base + j, j == BLOCKED_LEN - 1);
        random_phase(5);

        set_distance(0);
        random_phase(5);
        set_distance($urandom_range(3, 62));
        random_phase(5);
        set_distance(2);
        random_phase(5);
        set_distance($urandom_range(3, 62));
        random_phase(5);
        set_distance(63);
        random_phase(5);

        settle();
        $display("Sent %0d nonzeros, %0d closed columns, under %0d window settings;",
                 sent_count, column_count, setting_count);
        $display("checked %0d finished entries, incl. overflow, saturation and a long stall",
                 entries_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
